// File: design/ams_pkg.sv
package ams_pkg;

	// result status codes
	localparam logic [2:0] ST_RAN    = 3'd0;
	localparam logic [2:0] ST_HALT   = 3'd1;
	localparam logic [2:0] ST_DIVZ   = 3'd2;
	localparam logic [2:0] ST_BADOP  = 3'd3;
	localparam logic [2:0] ST_OVF    = 3'd4;
	localparam logic [2:0] ST_OFFEND = 3'd5;
	localparam logic [2:0] ST_STOP   = 3'd6;
	localparam logic [2:0] ST_LOADED = 3'd7;

	// io event codes
	localparam logic [1:0] IO_NONE    = 2'd0;
	localparam logic [1:0] IO_WRITE   = 2'd1;
	localparam logic [1:0] IO_NEWLINE = 2'd2;

	// item operation codes
	localparam logic OPER_LOAD = 1'b0;
	localparam logic OPER_STEP = 1'b1;

	// instruction opcodes
	localparam logic [5:0] OP_READ    = 6'd10;
	localparam logic [5:0] OP_WRITE   = 6'd11;
	localparam logic [5:0] OP_NEWLINE = 6'd12;
	localparam logic [5:0] OP_LOAD    = 6'd20;
	localparam logic [5:0] OP_STORE   = 6'd21;
	localparam logic [5:0] OP_ADD     = 6'd30;
	localparam logic [5:0] OP_SUB     = 6'd31;
	localparam logic [5:0] OP_DIV     = 6'd32;
	localparam logic [5:0] OP_MUL     = 6'd33;
	localparam logic [5:0] OP_ABS     = 6'd34;
	localparam logic [5:0] OP_POW     = 6'd35;
	localparam logic [5:0] OP_JMP     = 6'd40;
	localparam logic [5:0] OP_JNEG    = 6'd41;
	localparam logic [5:0] OP_JZERO   = 6'd42;
	localparam logic [5:0] OP_HALT    = 6'd43;

	// instruction word limit (opcode 44 and up is unknown)
	localparam logic [31:0] IR_LIMIT = 32'd4400;
	// reciprocal of 100 for instruction words below the limit
	localparam int unsigned DIV100_MUL = 5243;
	localparam int unsigned DIV100_SHR = 19;

endpackage

// File: design/accumulator_machine_step.sv
// Each step item passes the fetch and decode states; a known opcode then passes the operand
// state and, as it needs, the divide loop, the shared multiply loop (multiply and power), the
// final check and the advance state before the output state. Load items and stopped steps go
// straight to the output state. A negative power exponent with a nonzero base first runs the
// divider for the reciprocal. One item at a time; a stalled result holds the block in its
// output state. Reset: accumulator and counter zero, running set, words read zero until written.
module accumulator_machine_step #(
	parameter int MEM_WORDS = 100,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               operation,
	input  logic [6:0]         load_address,
	input  logic signed [14:0] load_word,
	input  logic signed [31:0] read_value,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [2:0]         status,
	output logic [1:0]         io_event,
	output logic signed [31:0] written_value,
	output logic [6:0]         counter_value,
	output logic signed [31:0] accumulator_value
);

	localparam int AW = $clog2(MEM_WORDS);
	localparam int DW = 32 + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);
	localparam int NW = 32 - FRAC_BITS;
	localparam logic [6:0]  MEM_LIM = 7'(MEM_WORDS);
	localparam logic [63:0] LIM_Q   = 64'(9999) << FRAC_BITS;
	localparam logic [31:0] ONE_Q   = 32'(1) << FRAC_BITS;
	localparam logic [31:0] MAG31   = 32'h8000_0000;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FETCH = 4'd1;
	localparam logic [3:0] S_DEC   = 4'd2;
	localparam logic [3:0] S_OPND  = 4'd3;
	localparam logic [3:0] S_DIV   = 4'd4;
	localparam logic [3:0] S_DIVD  = 4'd5;
	localparam logic [3:0] S_PW    = 4'd6;
	localparam logic [3:0] S_PW_RU = 4'd7;
	localparam logic [3:0] S_PW_XU = 4'd8;
	localparam logic [3:0] S_FIN   = 4'd9;
	localparam logic [3:0] S_ADV   = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	logic [3:0]         state_q;
	logic               running_q;
	logic [6:0]         pc_q;
	logic signed [31:0] acc_q;
	logic [6:0]         next_q;
	logic [2:0]         st_q;
	logic [1:0]         io_q;
	logic signed [31:0] wv_q;
	logic signed [31:0] rv_q;
	logic               bad_q;
	logic [5:0]         opc_q;
	logic [6:0]         opd_q;
	logic [12:0]        ir_lo_q;
	logic               dec_bad_q;

	// word store
	logic [31:0]          mem_q [MEM_WORDS];
	logic [MEM_WORDS-1:0] vld_q;
	logic [31:0]          rd_data_q;
	logic                 rd_ok_q;
	logic                 mem_we;
	logic [6:0]           mem_wa;
	logic [31:0]          mem_wd;
	logic [6:0]           mem_ra;
	logic signed [31:0]   rd_val;

	// arithmetic
	logic [63:0]    fin_mag_q;
	logic           fin_neg_q;
	logic [31:0]    r_mag_q;
	logic           r_neg_q;
	logic [31:0]    x_mag_q;
	logic           x_neg_q;
	logic [NW-1:0]  n_q;
	logic [63:0]    prod_q;
	logic [31:0]    mul_a;
	logic [63:0]    cl_shift;
	logic           cl_big;
	logic [31:0]    cl_mag;
	logic [31:0]    dv_rem_q;
	logic [DW-1:0]  dv_quo_q;
	logic [31:0]    dv_den_q;
	logic [CW-1:0]  dv_cnt_q;
	logic           dv_neg_q;
	logic           dv_pow_q;
	logic [32:0]    dv_sh;
	logic           dv_ge;
	logic           dv_big;

	// decode and operand helpers
	logic [31:0]        word_abs;
	logic [31:0]        ir_mag;
	logic [26:0]        ir_qm;
	logic [12:0]        opd_wide;
	logic [6:0]         dec_opd;
	logic               dec_known;
	logic [6:0]         next_pc;
	logic [31:0]        acc_abs;
	logic [31:0]        m_abs;
	logic [NW-1:0]      e_mag;
	logic signed [32:0] sum_s;
	logic [32:0]        sum_abs;
	logic               ovf;
	logic signed [31:0] acc_sat;
	logic signed [14:0] ld_clamp;
	logic signed [47:0] ld_scaled;
	logic [31:0]        ld_word32;
	logic               out_free;

	assign item_stall = (state_q != S_IDLE);
	assign out_free   = !result_valid || !result_stall;

	// scale and saturate a loaded word
	always_comb begin
		if (load_word > 15'sd9999)
			ld_clamp = 15'sd9999;
		else if (load_word < -15'sd9999)
			ld_clamp = -15'sd9999;
		else
			ld_clamp = load_word;
		ld_scaled = 48'(ld_clamp) <<< FRAC_BITS;
		if (ld_scaled > 48'sd2147483647)
			ld_word32 = 32'h7FFF_FFFF;
		else if (ld_scaled < -48'sd2147483648)
			ld_word32 = 32'h8000_0000;
		else
			ld_word32 = ld_scaled[31:0];
	end

	// memory port selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = load_address;
		mem_wd = ld_word32;
		mem_ra = pc_q;
		case (state_q)
			S_IDLE: begin
				mem_we = item_valid && (operation == ams_pkg::OPER_LOAD) &&
					(load_address < MEM_LIM);
			end
			S_DEC: begin
				mem_ra = dec_opd;
			end
			S_OPND: begin
				mem_wa = opd_q;
				mem_wd = (opc_q == ams_pkg::OP_READ) ? rv_q : acc_q;
				mem_we = ((opc_q == ams_pkg::OP_READ) || (opc_q == ams_pkg::OP_STORE)) &&
					(opd_q < MEM_LIM);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_wa[AW-1:0]] <= mem_wd;
		rd_data_q <= mem_q[mem_ra[AW-1:0]];
		rd_ok_q   <= (mem_ra < MEM_LIM) && vld_q[mem_ra[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (mem_we)
			vld_q[mem_wa[AW-1:0]] <= 1'b1;
	end

	assign rd_val = rd_ok_q ? rd_data_q : 32'sd0;

	// split the instruction word
	assign word_abs  = rd_val[31] ? (~rd_val + 32'd1) : rd_val;
	assign ir_mag    = word_abs >> FRAC_BITS;
	assign ir_qm     = 27'(ir_mag[12:0]) * 27'(ams_pkg::DIV100_MUL);
	assign opd_wide  = ir_lo_q - 13'(opc_q) * 13'd100;
	assign dec_opd   = opd_wide[6:0];

	always_comb begin
		case (opc_q)
			ams_pkg::OP_READ, ams_pkg::OP_WRITE, ams_pkg::OP_NEWLINE,
			ams_pkg::OP_LOAD, ams_pkg::OP_STORE, ams_pkg::OP_ADD, ams_pkg::OP_SUB,
			ams_pkg::OP_DIV, ams_pkg::OP_MUL, ams_pkg::OP_ABS, ams_pkg::OP_POW,
			ams_pkg::OP_JMP, ams_pkg::OP_JNEG, ams_pkg::OP_JZERO,
			ams_pkg::OP_HALT: dec_known = 1'b1;
			default: dec_known = 1'b0;
		endcase
	end

	// pick the counter value after the instruction
	always_comb begin
		case (opc_q)
			ams_pkg::OP_JMP: next_pc = opd_q;
			ams_pkg::OP_JNEG: next_pc = acc_q[31] ? opd_q : (pc_q + 7'd1);
			ams_pkg::OP_JZERO: next_pc = (acc_q == 32'sd0) ? opd_q : (pc_q + 7'd1);
			default: next_pc = pc_q + 7'd1;
		endcase
	end

	// operand helpers
	assign acc_abs = acc_q[31] ? (~acc_q + 32'd1) : acc_q;
	assign m_abs   = rd_val[31] ? (~rd_val + 32'd1) : rd_val;
	assign e_mag   = NW'(m_abs >> FRAC_BITS);
	assign sum_s   = (opc_q == ams_pkg::OP_SUB) ? (33'(acc_q) - 33'(rd_val)) :
		(33'(acc_q) + 33'(rd_val));
	assign sum_abs = sum_s[32] ? (~sum_s + 33'd1) : sum_s;

	// shared multiplier and clamp to +-2^31
	assign mul_a    = ((state_q == S_PW) && n_q[0]) ? r_mag_q : x_mag_q;
	assign cl_shift = prod_q >> FRAC_BITS;
	assign cl_big   = cl_shift > 64'(MAG31);
	assign cl_mag   = cl_big ? MAG31 : cl_shift[31:0];

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(x_mag_q);
	end

	// restoring divider step
	assign dv_sh  = {dv_rem_q, dv_quo_q[DW-1]};
	assign dv_ge  = dv_sh >= {1'b0, dv_den_q};
	assign dv_big = dv_quo_q > DW'(MAG31);

	// final accumulator check and saturation
	always_comb begin
		ovf = bad_q || (fin_mag_q > LIM_Q) ||
			(fin_neg_q ? (fin_mag_q > 64'(MAG31)) : (fin_mag_q > 64'h7FFF_FFFF));
		if (fin_neg_q)
			acc_sat = (fin_mag_q >= 64'(MAG31)) ? 32'sh8000_0000 : -fin_mag_q[31:0];
		else
			acc_sat = (fin_mag_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : fin_mag_q[31:0];
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				rv_q  <= read_value;
				io_q  <= ams_pkg::IO_NONE;
				wv_q  <= 32'sd0;
				bad_q <= 1'b0;
			end
			S_FETCH: begin
				ir_lo_q   <= ir_mag[12:0];
				opc_q     <= ir_qm[ams_pkg::DIV100_SHR +: 6];
				dec_bad_q <= rd_val[31] || (ir_mag >= ams_pkg::IR_LIMIT);
			end
			S_DEC: begin
				opd_q <= dec_opd;
			end
			S_OPND: begin
				next_q <= next_pc;
				case (opc_q)
					ams_pkg::OP_WRITE: begin
						io_q <= ams_pkg::IO_WRITE;
						wv_q <= rd_val;
					end
					ams_pkg::OP_NEWLINE: io_q <= ams_pkg::IO_NEWLINE;
					ams_pkg::OP_LOAD: begin
						fin_mag_q <= 64'(m_abs);
						fin_neg_q <= rd_val[31];
					end
					ams_pkg::OP_ADD, ams_pkg::OP_SUB: begin
						fin_mag_q <= 64'(sum_abs);
						fin_neg_q <= sum_s[32];
					end
					ams_pkg::OP_ABS: begin
						fin_mag_q <= 64'(acc_abs);
						fin_neg_q <= 1'b0;
					end
					ams_pkg::OP_DIV: begin
						dv_rem_q <= '0;
						dv_quo_q <= {acc_abs, {FRAC_BITS{1'b0}}};
						dv_den_q <= m_abs;
						dv_cnt_q <= CW'(DW);
						dv_neg_q <= acc_q[31] ^ rd_val[31];
						dv_pow_q <= 1'b0;
					end
					ams_pkg::OP_MUL: begin
						r_mag_q <= acc_abs;
						r_neg_q <= acc_q[31];
						x_mag_q <= m_abs;
						x_neg_q <= rd_val[31];
						n_q     <= NW'(1);
					end
					ams_pkg::OP_POW: begin
						r_mag_q <= ONE_Q;
						r_neg_q <= 1'b0;
						x_mag_q <= acc_abs;
						x_neg_q <= acc_q[31];
						n_q     <= e_mag;
						dv_rem_q <= '0;
						dv_quo_q <= DW'(1) << (2 * FRAC_BITS);
						dv_den_q <= acc_abs;
						dv_cnt_q <= CW'(DW);
						dv_neg_q <= acc_q[31];
						dv_pow_q <= 1'b1;
						if (rd_val[31] && (e_mag != '0) && (acc_q == 32'sd0)) begin
							bad_q     <= 1'b1;
							fin_mag_q <= 64'(MAG31);
							fin_neg_q <= 1'b0;
						end
					end
					default: begin
						io_q <= ams_pkg::IO_NONE;
					end
				endcase
			end
			S_DIV: begin
				dv_rem_q <= dv_ge ? 32'(dv_sh - {1'b0, dv_den_q}) : dv_sh[31:0];
				dv_quo_q <= {dv_quo_q[DW-2:0], dv_ge};
				dv_cnt_q <= dv_cnt_q - CW'(1);
			end
			S_DIVD: begin
				if (dv_pow_q) begin
					x_mag_q <= dv_big ? MAG31 : dv_quo_q[31:0];
					x_neg_q <= dv_neg_q;
					if (dv_big)
						bad_q <= 1'b1;
				end else begin
					fin_mag_q <= 64'(dv_quo_q);
					fin_neg_q <= dv_neg_q;
				end
			end
			S_PW: begin
				if (n_q == '0) begin
					fin_mag_q <= 64'(r_mag_q);
					fin_neg_q <= r_neg_q;
				end else if (!n_q[0]) begin
					n_q <= n_q >> 1;
				end
			end
			S_PW_RU: begin
				r_mag_q <= cl_mag;
				r_neg_q <= r_neg_q ^ x_neg_q;
				n_q     <= n_q >> 1;
				if (cl_big)
					bad_q <= 1'b1;
			end
			S_PW_XU: begin
				x_mag_q <= cl_mag;
				x_neg_q <= 1'b0;
				if (cl_big)
					bad_q <= 1'b1;
			end
			default: begin
				n_q <= n_q;
			end
		endcase
	end

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			running_q         <= 1'b1;
			pc_q              <= '0;
			acc_q             <= '0;
			st_q              <= ams_pkg::ST_RAN;
			result_valid      <= 1'b0;
			status            <= ams_pkg::ST_RAN;
			io_event          <= ams_pkg::IO_NONE;
			written_value     <= '0;
			counter_value     <= '0;
			accumulator_value <= '0;
		end else begin
			// drop a taken result beat unless a new one replaces it
			if (result_valid && !result_stall && (state_q != S_OUT))
				result_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						if (operation == ams_pkg::OPER_LOAD) begin
							st_q    <= ams_pkg::ST_LOADED;
							state_q <= S_OUT;
						end else if (!running_q) begin
							st_q    <= ams_pkg::ST_STOP;
							state_q <= S_OUT;
						end else begin
							st_q    <= ams_pkg::ST_RAN;
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: state_q <= S_DEC;
				S_DEC: begin
					if (dec_bad_q || !dec_known) begin
						st_q    <= ams_pkg::ST_BADOP;
						state_q <= S_OUT;
					end else begin
						state_q <= S_OPND;
					end
				end
				S_OPND: begin
					case (opc_q)
						ams_pkg::OP_LOAD, ams_pkg::OP_ADD, ams_pkg::OP_SUB,
						ams_pkg::OP_ABS: state_q <= S_FIN;
						ams_pkg::OP_MUL: state_q <= S_PW;
						ams_pkg::OP_DIV: begin
							if (rd_val == 32'sd0) begin
								st_q    <= ams_pkg::ST_DIVZ;
								state_q <= S_OUT;
							end else begin
								state_q <= S_DIV;
							end
						end
						ams_pkg::OP_POW: begin
							if (rd_val[31] && (e_mag != '0))
								state_q <= (acc_q == 32'sd0) ? S_FIN : S_DIV;
							else
								state_q <= S_PW;
						end
						ams_pkg::OP_HALT: begin
							st_q    <= ams_pkg::ST_HALT;
							state_q <= S_OUT;
						end
						default: state_q <= S_ADV;
					endcase
				end
				S_DIV: begin
					if (dv_cnt_q == CW'(1))
						state_q <= S_DIVD;
				end
				S_DIVD: state_q <= dv_pow_q ? S_PW : S_FIN;
				S_PW: begin
					if (n_q == '0)
						state_q <= S_FIN;
					else if (n_q[0])
						state_q <= S_PW_RU;
					else
						state_q <= S_PW_XU;
				end
				S_PW_RU: state_q <= ((n_q >> 1) != '0) ? S_PW_XU : S_PW;
				S_PW_XU: state_q <= S_PW;
				S_FIN: begin
					acc_q <= acc_sat;
					if (ovf) begin
						st_q    <= ams_pkg::ST_OVF;
						state_q <= S_OUT;
					end else begin
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					if (next_q >= MEM_LIM)
						st_q <= ams_pkg::ST_OFFEND;
					else
						pc_q <= next_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					// hold until the result register frees up
					if (out_free) begin
						result_valid      <= 1'b1;
						status            <= st_q;
						io_event          <= io_q;
						written_value     <= wv_q;
						counter_value     <= pc_q;
						accumulator_value <= acc_q;
						if ((st_q != ams_pkg::ST_RAN) && (st_q != ams_pkg::ST_STOP) &&
							(st_q != ams_pkg::ST_LOADED))
							running_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: dv/tb_top.sv
module tb_top;

	localparam int MEM_WORDS = 100;
	localparam int FRAC_BITS = 16;
	localparam longint ONE_Q = longint'(1) << FRAC_BITS;
	localparam longint LIM31 = longint'(1) << 31;
	localparam longint INT32_MAX = 64'sd2147483647;
	localparam longint INT32_MIN = -64'sd2147483648;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct packed {
		logic [2:0]         status;
		logic [1:0]         io_event;
		logic signed [31:0] written_value;
		logic [6:0]         counter_value;
		logic signed [31:0] accumulator_value;
	} machine_result_t;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	logic operation;
	logic [6:0] load_address;
	logic signed [14:0] load_word;
	logic signed [31:0] read_value;
	logic result_valid;
	logic result_stall;
	logic [2:0] status;
	logic [1:0] io_event;
	logic signed [31:0] written_value;
	logic [6:0] counter_value;
	logic signed [31:0] accumulator_value;

	// machine copy used for prediction
	logic signed [31:0] mach_mem [MEM_WORDS];
	logic signed [31:0] mach_acc;
	int unsigned mach_pc;
	bit mach_running;

	machine_result_t pending_results[$];
	int mismatches;
	int idle_cycles;
	bit out_idle_on;
	bit in_idle_on;
	bit hold_off;
	bit timed_out;

	accumulator_machine_step #(
		.MEM_WORDS(MEM_WORDS),
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.operation(operation),
		.load_address(load_address),
		.load_word(load_word),
		.read_value(read_value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.status(status),
		.io_event(io_event),
		.written_value(written_value),
		.counter_value(counter_value),
		.accumulator_value(accumulator_value)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// fixed-point helpers
	function automatic longint shr_trunc(longint x);
		if (x >= 0) return x >>> FRAC_BITS;
		return -((-x) >>> FRAC_BITS);
	endfunction

	function automatic longint sat_word(longint v);
		if (v > INT32_MAX) return INT32_MAX;
		if (v < INT32_MIN) return INT32_MIN;
		return v;
	endfunction

	function automatic longint clamp_big(longint v, ref bit big);
		if (v > LIM31) begin
			big = 1'b1;
			return LIM31;
		end
		if (v < -LIM31) begin
			big = 1'b1;
			return -LIM31;
		end
		return v;
	endfunction

	function automatic longint mem_value(longint a);
		if (a >= 0 && a < MEM_WORDS) return longint'(mach_mem[a]);
		return 0;
	endfunction

	function automatic longint fixed_power(longint x, longint e, ref bit bad);
		longint r;
		longint n;
		bit big;
		r = ONE_Q;
		big = 1'b0;
		if (e < 0) begin
			if (x == 0) begin
				bad = 1'b1;
				return LIM31;
			end
			x = clamp_big((ONE_Q * ONE_Q) / x, big);
			n = -e;
		end else begin
			n = e;
		end
		while (n != 0) begin
			if (n[0]) r = clamp_big(shr_trunc(r * x), big);
			n = n >> 1;
			if (n != 0) x = clamp_big(shr_trunc(x * x), big);
		end
		if (big) bad = 1'b1;
		return r;
	endfunction

	// advance the machine copy by one item and return the expected result
	function automatic machine_result_t machine_advance(logic oper, logic [6:0] addr,
			logic signed [14:0] word, logic signed [31:0] rd);
		machine_result_t res;
		longint w, ir, opc, opd, r, m, nxt, lim;
		bit acc_write, bad;
		res = '0;
		r = 0;
		acc_write = 1'b0;
		bad = 1'b0;
		if (oper == ams_pkg::OPER_LOAD) begin
			w = longint'(word);
			if (w > 9999) w = 9999;
			if (w < -9999) w = -9999;
			if (addr < MEM_WORDS) mach_mem[addr] = 32'(sat_word(w * ONE_Q));
			res.status = ams_pkg::ST_LOADED;
		end else if (!mach_running) begin
			res.status = ams_pkg::ST_STOP;
		end else begin
			res.status = ams_pkg::ST_RAN;
			nxt = longint'(mach_pc) + 1;
			ir = shr_trunc(mem_value(mach_pc));
			opc = ir / 100;
			opd = ir % 100;
			m = mem_value(opd);
			case (opc)
				longint'(ams_pkg::OP_READ):
					if (opd >= 0 && opd < MEM_WORDS) mach_mem[opd] = rd;
				longint'(ams_pkg::OP_WRITE): begin
					res.io_event = ams_pkg::IO_WRITE;
					res.written_value = 32'(m);
				end
				longint'(ams_pkg::OP_NEWLINE): res.io_event = ams_pkg::IO_NEWLINE;
				longint'(ams_pkg::OP_LOAD): begin
					r = m;
					acc_write = 1'b1;
				end
				longint'(ams_pkg::OP_STORE):
					if (opd >= 0 && opd < MEM_WORDS) mach_mem[opd] = mach_acc;
				longint'(ams_pkg::OP_ADD): begin
					r = longint'(mach_acc) + m;
					acc_write = 1'b1;
				end
				longint'(ams_pkg::OP_SUB): begin
					r = longint'(mach_acc) - m;
					acc_write = 1'b1;
				end
				longint'(ams_pkg::OP_DIV): begin
					if (m == 0) res.status = ams_pkg::ST_DIVZ;
					else begin
						r = (longint'(mach_acc) * ONE_Q) / m;
						acc_write = 1'b1;
					end
				end
				longint'(ams_pkg::OP_MUL): begin
					r = shr_trunc(longint'(mach_acc) * m);
					acc_write = 1'b1;
				end
				longint'(ams_pkg::OP_ABS): begin
					r = mach_acc < 0 ? -longint'(mach_acc) : longint'(mach_acc);
					acc_write = 1'b1;
				end
				longint'(ams_pkg::OP_POW): begin
					r = fixed_power(longint'(mach_acc), shr_trunc(m), bad);
					acc_write = 1'b1;
				end
				longint'(ams_pkg::OP_JMP): nxt = opd;
				longint'(ams_pkg::OP_JNEG): if (mach_acc < 0) nxt = opd;
				longint'(ams_pkg::OP_JZERO): if (mach_acc == 0) nxt = opd;
				longint'(ams_pkg::OP_HALT): res.status = ams_pkg::ST_HALT;
				default: res.status = ams_pkg::ST_BADOP;
			endcase
			if (acc_write) begin
				lim = 9999 * ONE_Q;
				mach_acc = 32'(sat_word(r));
				if (bad || r > lim || r < -lim || r > INT32_MAX || r < INT32_MIN)
					res.status = ams_pkg::ST_OVF;
			end
			if (res.status == ams_pkg::ST_RAN) begin
				if (nxt < 0 || nxt >= MEM_WORDS) res.status = ams_pkg::ST_OFFEND;
				else mach_pc = int'(nxt);
			end
			if (res.status != ams_pkg::ST_RAN) mach_running = 1'b0;
		end
		res.counter_value = 7'(mach_pc);
		res.accumulator_value = mach_acc;
		return res;
	endfunction

	// send one beat; predict at acceptance
	task automatic send_beat(logic oper, logic [6:0] addr, logic signed [14:0] word,
			logic signed [31:0] rd);
		while (in_idle_on && $urandom_range(99) < 30) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		operation <= oper;
		load_address <= addr;
		load_word <= word;
		read_value <= rd;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		pending_results.push_back(machine_advance(oper, addr, word, rd));
		@(negedge clk);
	endtask

	task automatic load_cell(int addr, int word);
		send_beat(ams_pkg::OPER_LOAD, 7'(addr), 15'(word), 32'($urandom));
	endtask

	task automatic step_once();
		send_beat(ams_pkg::OPER_STEP, 7'($urandom), 15'($urandom), 32'($urandom));
	endtask

	// drop the input and wait until every expected result has come
	task automatic wait_drained();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	function automatic int rand_instr();
		int ops [15];
		ops = '{10, 11, 12, 20, 21, 30, 31, 32, 33, 34, 35, 40, 41, 42, 43};
		return ops[$urandom_range(14)] * 100 + $urandom_range(99);
	endfunction

	// directed: extremes of the load fields and several opcodes
	task automatic test_directed();
		load_cell(127, 9999);
		load_cell(99, 16383);
		load_cell(98, -16384);
		load_cell(50, 7);
		load_cell(51, -2);
		load_cell(52, 0);
		load_cell(0, 2050);
		load_cell(1, 3351);
		load_cell(2, 3550);
		load_cell(3, 3451);
		load_cell(4, 1199);
		load_cell(5, 1200);
		load_cell(6, 1053);
		load_cell(7, 3253);
		step_once();
		step_once();
		step_once();
		step_once();
		step_once();
		step_once();
		send_beat(ams_pkg::OPER_STEP, 7'h7f, 15'h7fff, 32'sh7fffffff);
		send_beat(ams_pkg::OPER_STEP, 7'h00, 15'h4000, 32'sh80000000);
		step_once();
		step_once();
	endtask

	// random programs: the machine halts for good, so each program is run while
	// it can, mostly well-formed instructions with random operands
	task automatic test_programs(int count);
		int sent;
		int kind;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(99);
			if (kind < 25) begin
				load_cell($urandom_range(99), rand_instr());
			end else if (kind < 35) begin
				load_cell($urandom_range(127), int'($signed(15'($urandom))));
			end else if (kind < 45) begin
				load_cell($urandom_range(40, 99), $urandom_range(19998) - 9999);
			end else begin
				step_once();
			end
			sent++;
		end
	endtask

	// hold results back long enough for the block to stall its input
	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			test_programs(20);
		join
		wait_drained();
		test_programs(10);
		wait_drained();
	endtask

	task automatic test_no_idle();
		in_idle_on = 1'b0;
		out_idle_on = 1'b0;
		test_programs(100);
		in_idle_on = 1'b1;
		out_idle_on = 1'b1;
	endtask

	// receiver side: random stall, forced hold-off
	always @(negedge clk) begin
		if (!arst_n) result_stall <= 1'b1;
		else result_stall <= hold_off || (out_idle_on && $urandom_range(99) < 30);
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		machine_result_t got;
		machine_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			got = '{status, io_event, written_value, counter_value, accumulator_value};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) timed_out <= 1'b1;
	end

	always @(posedge timed_out) begin
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		hold_off = 1'b0;
		in_idle_on = 1'b1;
		out_idle_on = 1'b1;
		for (int i = 0; i < MEM_WORDS; i++) mach_mem[i] = '0;
		mach_acc = '0;
		mach_pc = 0;
		mach_running = 1'b1;
		arst_n = 1'b0;
		item_valid = 1'b0;
		operation = ams_pkg::OPER_LOAD;
		load_address = '0;
		load_word = '0;
		read_value = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		wait_drained();
		test_programs(180);
		test_backpressure();
		test_no_idle();
		test_programs(180);
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
